/* src/backward_pauli_error_propagation_core_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the backward pauli propagation core
// ----------------------------------------------------------------------------
`ifndef BACKWARD_PAULI_ERROR_PROPAGATION_CORE_MACROS_SVH
`define BACKWARD_PAULI_ERROR_PROPAGATION_CORE_MACROS_SVH

// same-cycle implication, held off while reset is low
`define BPEP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpep assertion failed");

// next-cycle implication, checked during reset as well
`define BPEP_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bpep assertion failed");

`endif

/* src/bpep_pkg.sv */
// ----------------------------------------------------------------------------
// bpep_pkg
// shared types and constants of the backward pauli propagation core
// ----------------------------------------------------------------------------
package bpep_pkg;

    localparam int NUM_QUBITS_DEF = 64;
    localparam int ROW_BITS_DEF   = 64;
    localparam int QUEUE_DEPTH    = 4;
    localparam int KIND_W         = 3;
    localparam int QUBIT_W        = 6;
    localparam int NOISE_W        = 20;
    localparam int ROW_MAX        = 64;

    typedef logic [ROW_MAX-1:0] row_max_t;
    typedef logic [NOISE_W-1:0] noise_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 3'd0,
        KIND_DEPOL = 3'd1,
        KIND_MEAS  = 3'd2,
        KIND_RESET = 3'd3,
        KIND_CNOT  = 3'd4,
        KIND_HAD   = 3'd5,
        KIND_PHASE = 3'd6,
        KIND_PAULI = 3'd7
    } kind_e;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [QUBIT_W-1:0] qubit_a;
        logic [QUBIT_W-1:0] qubit_b;
        row_max_t           meas_mask;
    } in_beat_t;

    typedef struct packed {
        noise_t   noise_index;
        row_max_t x_row;
        row_max_t y_row;
        row_max_t z_row;
        logic     overrun;
    } out_beat_t;

    // one classified gate waiting for the back end
    typedef struct packed {
        kind_e              op;
        logic [QUBIT_W-1:0] qubit_a;
        logic [QUBIT_W-1:0] qubit_b;
        logic               a_ok;
        row_max_t           meas_mask;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CNOT_Y
    } back_state_e;

endpackage

/* src/backward_pauli_error_propagation_core.sv */
// a depolarize beat is popped from the queue in idle and loaded into the output register in
// exec once that register is free; the back end handles one gate at a time, a cnot adding
// a second write state since the row memories have a single write port; pauli gates, cnots
// with control equal to target and absent-qubit gates except start and depol drop at front
// reset: synchronous active-low aresetn clears the queue, counters and all row valid bits
// ----------------------------------------------------------------------------
// backward_pauli_error_propagation_core
// backward pauli frame propagation over a reversed clifford circuit
// ----------------------------------------------------------------------------
`include "backward_pauli_error_propagation_core_macros.svh"

module backward_pauli_error_propagation_core #(
    parameter int NUM_QUBITS = bpep_pkg::NUM_QUBITS_DEF,
    parameter int ROW_BITS   = bpep_pkg::ROW_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // gate beats, last gate first
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bpep_pkg::in_beat_t   s_data,
    // noise row beats
    output logic                 m_valid,
    input  logic                 m_ready,
    output bpep_pkg::out_beat_t  m_data,
    // noise budget register
    input  logic                 cfg_wr_en,
    input  bpep_pkg::noise_t     cfg_wr_data
);

    // total noise count, copied into the down counter on a start gate
    bpep_pkg::noise_t noise_budget_reg, noise_budget_next;

    bpep_pkg::q_status_t q_stat;
    bpep_pkg::q_entry_t  q_wdata;
    bpep_pkg::q_entry_t  q_head;
    logic                q_push;
    logic                q_pop;
    logic                ovr_beat;

    assign noise_budget_next = cfg_wr_en ? cfg_wr_data : noise_budget_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_budget_reg <= '0;
        end else begin
            noise_budget_reg <= noise_budget_next;
        end
    end

    // front: handshake and classification, drops gates with no effect
    bpep_front #(.NUM_QUBITS(NUM_QUBITS)) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    // decoupling queue so the input side keeps taking beats while the back end works
    bpep_queue #(.DEPTH(bpep_pkg::QUEUE_DEPTH)) u_queue (
        .clk   (aclk),
        .rst_n (aresetn),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    // back: row memories, noise counter and the output register
    bpep_back #(.NUM_QUBITS(NUM_QUBITS), .ROW_BITS(ROW_BITS)) u_back (
        .clk          (aclk),
        .rst_n        (aresetn),
        .q_head       (q_head),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .noise_budget (noise_budget_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    // a beat presented with the overrun flag set
    assign ovr_beat = m_valid && m_data.overrun;

    // once the counter has run out, every later noise beat carries index zero until the next start
    `BPEP_ASSERT_IMPLY(a_overrun_index_zero, aclk, aresetn, ovr_beat, m_data.noise_index == '0)
    // reset empties the output register
    `BPEP_ASSERT_NEXT(a_reset_no_beat, aclk, !aresetn, !m_valid)

endmodule

/* src/bpep_ram.sv */
// ----------------------------------------------------------------------------
// bpep_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module bpep_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    ra_addr,
    input  logic [AW-1:0]    rb_addr,
    output logic [WIDTH-1:0] ra_data,
    output logic [WIDTH-1:0] rb_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        ra_data <= mem_reg[ra_addr];
        rb_data <= mem_reg[rb_addr];
    end

endmodule

/* src/bpep_front.sv */
// ----------------------------------------------------------------------------
// bpep_front
// accepts gate beats, drops gates with no effect, queues the rest
// ----------------------------------------------------------------------------
module bpep_front #(
    parameter int NUM_QUBITS = bpep_pkg::NUM_QUBITS_DEF
) (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bpep_pkg::in_beat_t   s_data,
    input  bpep_pkg::q_status_t  q_stat,
    output logic                 q_push,
    output bpep_pkg::q_entry_t   q_wdata
);

    logic a_ok;
    logic b_ok;
    logic keep;

    assign a_ok = (int'(s_data.qubit_a) < NUM_QUBITS);
    assign b_ok = (int'(s_data.qubit_b) < NUM_QUBITS);

    always_comb begin
        unique case (bpep_pkg::kind_e'(s_data.kind))
            bpep_pkg::KIND_START: keep = 1'b1;
            bpep_pkg::KIND_DEPOL: keep = 1'b1;
            bpep_pkg::KIND_MEAS:  keep = a_ok;
            bpep_pkg::KIND_RESET: keep = a_ok;
            bpep_pkg::KIND_CNOT:  keep = a_ok && b_ok && (s_data.qubit_a != s_data.qubit_b);
            bpep_pkg::KIND_HAD:   keep = a_ok;
            bpep_pkg::KIND_PHASE: keep = a_ok;
            default:              keep = 1'b0;
        endcase
    end

    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready && keep;

    always_comb begin
        q_wdata.op        = bpep_pkg::kind_e'(s_data.kind);
        q_wdata.qubit_a   = s_data.qubit_a;
        q_wdata.qubit_b   = s_data.qubit_b;
        q_wdata.a_ok      = a_ok;
        q_wdata.meas_mask = s_data.meas_mask;
    end

endmodule

/* src/bpep_queue.sv */
// ----------------------------------------------------------------------------
// bpep_queue
// short fifo of classified gates between front and back
// ----------------------------------------------------------------------------
module bpep_queue #(
    parameter int DEPTH = bpep_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bpep_pkg::q_entry_t  wdata,
    input  logic                pop,
    output bpep_pkg::q_entry_t  head,
    output bpep_pkg::q_status_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bpep_pkg::q_entry_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* src/bpep_back.sv */
// ----------------------------------------------------------------------------
// bpep_back
// executes queued gates on the x, y and z row memories, emits noise rows
// ----------------------------------------------------------------------------
module bpep_back #(
    parameter int NUM_QUBITS = bpep_pkg::NUM_QUBITS_DEF,
    parameter int ROW_BITS   = bpep_pkg::ROW_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bpep_pkg::q_entry_t  q_head,
    input  bpep_pkg::q_status_t q_stat,
    output logic                q_pop,
    input  bpep_pkg::noise_t    noise_budget,
    output logic                m_valid,
    input  logic                m_ready,
    output bpep_pkg::out_beat_t m_data
);

    localparam int AW = (NUM_QUBITS > 1) ? $clog2(NUM_QUBITS) : 1;

    typedef logic [AW-1:0]       addr_t;
    typedef logic [ROW_BITS-1:0] row_t;

    bpep_pkg::back_state_e state_reg, state_next;
    bpep_pkg::q_entry_t    op_reg, op_next;
    bpep_pkg::noise_t      cnt_reg, cnt_next;
    logic                  exh_reg, exh_next;
    logic                  vx_reg [NUM_QUBITS];
    logic                  vy_reg [NUM_QUBITS];
    logic                  vz_reg [NUM_QUBITS];
    logic                  vx_next [NUM_QUBITS];
    logic                  vy_next [NUM_QUBITS];
    logic                  vz_next [NUM_QUBITS];
    row_t                  ynew_reg, ynew_next;
    logic                  out_valid_reg, out_valid_next;
    bpep_pkg::out_beat_t   out_reg, out_next;

    addr_t rd_a, rd_b, aa, ab;
    logic  x_we, y_we, z_we;
    addr_t x_wa, y_wa, z_wa;
    row_t  x_wd, y_wd, z_wd;
    row_t  x_ra, x_rb, y_ra, y_rb, z_ra, z_rb;
    row_t  xa, xb, ya, yb, za, zb, mask;
    logic  out_free;

    bpep_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_QUBITS)) u_ram_x (
        .clk(clk), .we(x_we), .waddr(x_wa), .wdata(x_wd),
        .ra_addr(rd_a), .rb_addr(rd_b), .ra_data(x_ra), .rb_data(x_rb)
    );
    bpep_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_QUBITS)) u_ram_y (
        .clk(clk), .we(y_we), .waddr(y_wa), .wdata(y_wd),
        .ra_addr(rd_a), .rb_addr(rd_b), .ra_data(y_ra), .rb_data(y_rb)
    );
    bpep_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_QUBITS)) u_ram_z (
        .clk(clk), .we(z_we), .waddr(z_wa), .wdata(z_wd),
        .ra_addr(rd_a), .rb_addr(rd_b), .ra_data(z_ra), .rb_data(z_rb)
    );

    assign aa   = addr_t'(op_reg.qubit_a);
    assign ab   = addr_t'(op_reg.qubit_b);
    assign mask = op_reg.meas_mask[ROW_BITS-1:0];

    // rows that were never written since clear read as zero
    assign xa = (op_reg.a_ok && vx_reg[aa]) ? x_ra : '0;
    assign ya = (op_reg.a_ok && vy_reg[aa]) ? y_ra : '0;
    assign za = (op_reg.a_ok && vz_reg[aa]) ? z_ra : '0;
    assign xb = (op_reg.op == bpep_pkg::KIND_CNOT && vx_reg[ab]) ? x_rb : '0;
    assign yb = (op_reg.op == bpep_pkg::KIND_CNOT && vy_reg[ab]) ? y_rb : '0;
    assign zb = (op_reg.op == bpep_pkg::KIND_CNOT && vz_reg[ab]) ? z_rb : '0;

    assign out_free = !out_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpep_pkg::ST_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = bpep_pkg::ST_EXEC;
                end
            end
            bpep_pkg::ST_EXEC: begin
                if (op_reg.op == bpep_pkg::KIND_CNOT) begin
                    state_next = bpep_pkg::ST_CNOT_Y;
                end else if (op_reg.op != bpep_pkg::KIND_DEPOL || out_free) begin
                    state_next = bpep_pkg::ST_IDLE;
                end
            end
            bpep_pkg::ST_CNOT_Y: state_next = bpep_pkg::ST_IDLE;
            default:             state_next = bpep_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        q_pop          = 1'b0;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        exh_next       = exh_reg;
        ynew_next      = ynew_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vz_next        = vz_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        rd_a           = aa;
        rd_b           = ab;
        x_we = 1'b0; x_wa = aa; x_wd = '0;
        y_we = 1'b0; y_wa = aa; y_wd = '0;
        z_we = 1'b0; z_wa = aa; z_wd = '0;

        unique case (state_reg)
            bpep_pkg::ST_IDLE: begin
                rd_a = addr_t'(q_head.qubit_a);
                rd_b = addr_t'(q_head.qubit_b);
                if (!q_stat.empty) begin
                    q_pop   = 1'b1;
                    op_next = q_head;
                end
            end
            bpep_pkg::ST_EXEC: begin
                unique case (op_reg.op)
                    bpep_pkg::KIND_START: begin
                        for (int i = 0; i < NUM_QUBITS; i++) begin
                            vx_next[i] = 1'b0;
                            vy_next[i] = 1'b0;
                            vz_next[i] = 1'b0;
                        end
                        cnt_next = noise_budget;
                        exh_next = 1'b0;
                    end
                    bpep_pkg::KIND_DEPOL: begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            out_next.x_row = bpep_pkg::row_max_t'(xa);
                            out_next.y_row = bpep_pkg::row_max_t'(ya);
                            out_next.z_row = bpep_pkg::row_max_t'(za);
                            if (cnt_reg != '0) begin
                                cnt_next             = cnt_reg - 1'b1;
                                out_next.noise_index = cnt_reg - 1'b1;
                                out_next.overrun     = exh_reg;
                            end else begin
                                exh_next             = 1'b1;
                                out_next.noise_index = '0;
                                out_next.overrun     = 1'b1;
                            end
                        end
                    end
                    bpep_pkg::KIND_MEAS: begin
                        x_we = 1'b1; x_wd = xa ^ mask;
                        y_we = 1'b1; y_wd = xa ^ mask;
                        vx_next[aa] = 1'b1;
                        vy_next[aa] = 1'b1;
                        vz_next[aa] = 1'b0;
                    end
                    bpep_pkg::KIND_RESET: begin
                        vx_next[aa] = 1'b0;
                        vy_next[aa] = 1'b0;
                        vz_next[aa] = 1'b0;
                    end
                    bpep_pkg::KIND_CNOT: begin
                        x_we = 1'b1; x_wd = xa ^ xb;
                        y_we = 1'b1; y_wd = ya ^ xb;
                        z_we = 1'b1; z_wa = ab; z_wd = zb ^ za;
                        ynew_next   = yb ^ za;
                        vx_next[aa] = 1'b1;
                        vy_next[aa] = 1'b1;
                        vz_next[ab] = 1'b1;
                    end
                    bpep_pkg::KIND_HAD: begin
                        x_we = 1'b1; x_wd = za;
                        z_we = 1'b1; z_wd = xa;
                        vx_next[aa] = 1'b1;
                        vz_next[aa] = 1'b1;
                    end
                    bpep_pkg::KIND_PHASE: begin
                        x_we = 1'b1; x_wd = ya;
                        y_we = 1'b1; y_wd = xa;
                        vx_next[aa] = 1'b1;
                        vy_next[aa] = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            bpep_pkg::ST_CNOT_Y: begin
                // second write of cnot, target y row
                y_we = 1'b1; y_wa = ab; y_wd = ynew_reg;
                vy_next[ab] = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg     <= bpep_pkg::ST_IDLE;
            cnt_reg       <= '0;
            exh_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUBITS; i++) begin
                vx_reg[i] <= 1'b0;
                vy_reg[i] <= 1'b0;
                vz_reg[i] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            exh_reg       <= exh_next;
            out_valid_reg <= out_valid_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            vz_reg        <= vz_next;
        end
    end

    always_ff @(posedge clk) begin
        op_reg   <= op_next;
        ynew_reg <= ynew_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* dv/bpep_noise_row_checker.sv */
// ----------------------------------------------------------------------------
// bpep_noise_row_checker
// watches the gate and noise row channels, keeps its own copy of the
// propagation rows and compares every noise row beat with the predicted one
// ----------------------------------------------------------------------------
module bpep_noise_row_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bpep_pkg::in_beat_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bpep_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  bpep_pkg::noise_t    cfg_wr_data,
    output int                  fail_count,
    output int                  rows_pending,
    output int                  rows_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    bpep_pkg::row_max_t  x_rows [bpep_pkg::NUM_QUBITS_DEF];
    bpep_pkg::row_max_t  y_rows [bpep_pkg::NUM_QUBITS_DEF];
    bpep_pkg::row_max_t  z_rows [bpep_pkg::NUM_QUBITS_DEF];
    bpep_pkg::noise_t    noise_left;
    logic                exhausted;
    bpep_pkg::noise_t    noise_budget;
    bpep_pkg::out_beat_t pending_rows [$];
    int                  n_fail    = 0;
    int                  n_checked = 0;

    task automatic clear_rows();
        for (int q = 0; q < bpep_pkg::NUM_QUBITS_DEF; q++) begin
            x_rows[q] = '0;
            y_rows[q] = '0;
            z_rows[q] = '0;
        end
    endtask

    // one gate of the reversed circuit; a depolarize gate queues its rows
    task automatic propagate_gate(bpep_pkg::in_beat_t g);
        logic [bpep_pkg::QUBIT_W-1:0] qa;
        logic [bpep_pkg::QUBIT_W-1:0] qb;
        bpep_pkg::row_max_t           xt;
        bpep_pkg::row_max_t           zc;
        bpep_pkg::row_max_t           t;
        bpep_pkg::out_beat_t          r;
        qa = g.qubit_a;
        qb = g.qubit_b;
        case (bpep_pkg::kind_e'(g.kind))
            bpep_pkg::KIND_START: begin
                clear_rows();
                noise_left = noise_budget;
                exhausted  = 1'b0;
            end
            bpep_pkg::KIND_DEPOL: begin
                if (noise_left != '0) begin
                    noise_left    = noise_left - 1'b1;
                    r.noise_index = noise_left;
                end else begin
                    exhausted     = 1'b1;
                    r.noise_index = '0;
                end
                r.x_row   = x_rows[qa];
                r.y_row   = y_rows[qa];
                r.z_row   = z_rows[qa];
                r.overrun = exhausted;
                pending_rows.push_back(r);
            end
            bpep_pkg::KIND_MEAS: begin
                x_rows[qa] = x_rows[qa] ^ g.meas_mask;
                y_rows[qa] = x_rows[qa];
                z_rows[qa] = '0;
            end
            bpep_pkg::KIND_RESET: begin
                x_rows[qa] = '0;
                y_rows[qa] = '0;
                z_rows[qa] = '0;
            end
            bpep_pkg::KIND_CNOT: begin
                // control equal to target leaves everything alone
                if (qa != qb) begin
                    xt = x_rows[qb];
                    zc = z_rows[qa];
                    x_rows[qa] = x_rows[qa] ^ xt;
                    y_rows[qa] = y_rows[qa] ^ xt;
                    z_rows[qb] = z_rows[qb] ^ zc;
                    y_rows[qb] = y_rows[qb] ^ zc;
                end
            end
            bpep_pkg::KIND_HAD: begin
                t          = x_rows[qa];
                x_rows[qa] = z_rows[qa];
                z_rows[qa] = t;
            end
            bpep_pkg::KIND_PHASE: begin
                t          = x_rows[qa];
                x_rows[qa] = y_rows[qa];
                y_rows[qa] = t;
            end
            default: ;
        endcase
    endtask

    task automatic compare_rows(bpep_pkg::out_beat_t got);
        bpep_pkg::out_beat_t want;
        if (pending_rows.size() == 0) begin
            if (n_fail < 10)
                $display("%0t: noise beat with none pending: idx=%05h x=%016h y=%016h z=%016h ovr=%0b",
                         $realtime, got.noise_index, got.x_row, got.y_row, got.z_row,
                         got.overrun);
            n_fail++;
        end else begin
            want = pending_rows.pop_front();
            n_checked++;
            if (want.noise_index !== got.noise_index || want.x_row !== got.x_row ||
                want.y_row !== got.y_row || want.z_row !== got.z_row ||
                want.overrun !== got.overrun) begin
                if (n_fail < 10) begin
                    $display("%0t: noise beat mismatch", $realtime);
                    $display("  expected idx=%05h x=%016h y=%016h z=%016h ovr=%0b",
                             want.noise_index, want.x_row, want.y_row, want.z_row,
                             want.overrun);
                    $display("  actual   idx=%05h x=%016h y=%016h z=%016h ovr=%0b",
                             got.noise_index, got.x_row, got.y_row, got.z_row, got.overrun);
                end
                n_fail++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_rows();
            noise_left   = '0;
            exhausted    = 1'b0;
            noise_budget = '0;
            pending_rows.delete();
        end else begin
            if (m_valid && m_ready)
                compare_rows(m_data);
            if (cfg_wr_en)
                noise_budget = cfg_wr_data;
            if (s_valid && s_ready)
                propagate_gate(s_data);
        end
        fail_count   <= n_fail;
        rows_pending <= pending_rows.size();
        rows_checked <= n_checked;
    end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives reversed clifford circuits into the backward pauli propagation core
// with random idle and stall bursts, rewrites the noise budget between circuits,
// and leaves row prediction and comparison to the checker beside the core
// ----------------------------------------------------------------------------
module tb_top ();
    timeunit 1ns;
    timeprecision 1ps;

    // run length guard, far above the slowest legal run
    localparam int CYCLE_LIMIT  = 400000;
    // cycles for gates without a noise beat to leave the core's queue
    localparam int SETTLE_CYCLES = 32;
    localparam int GATE_TARGET   = 1750;
    localparam int QUIET_FROM    = 1500;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    bpep_pkg::in_beat_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b1;
    bpep_pkg::out_beat_t m_data;
    logic                cfg_wr_en   = 1'b0;
    bpep_pkg::noise_t    cfg_wr_data = '0;

    int fail_count;
    int rows_pending;
    int rows_checked;
    int cycle_count  = 0;
    int gates_sent   = 0;
    int circuits_run = 0;
    bit quiet        = 1'b0;   // no idles or stalls in the closing part

    backward_pauli_error_propagation_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    bpep_noise_row_checker rows_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .rows_pending(rows_pending),
        .rows_checked(rows_checked)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d noise beats still pending",
                     cycle_count, rows_pending);
            $display("** backward_pauli_error_propagation_core: FAILED **");
            $finish;
        end
    end

    // receiver side: random stall bursts, none once quiet
    initial begin
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    function automatic bpep_pkg::in_beat_t gate(bpep_pkg::kind_e k,
                                                logic [bpep_pkg::QUBIT_W-1:0] qa,
                                                logic [bpep_pkg::QUBIT_W-1:0] qb,
                                                bpep_pkg::row_max_t mask);
        bpep_pkg::in_beat_t g;
        g.kind      = k;
        g.qubit_a   = qa;
        g.qubit_b   = qb;
        g.meas_mask = mask;
        return g;
    endfunction

    // one gate beat; valid stays up across back-to-back beats
    task automatic send_gate(bpep_pkg::in_beat_t g);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= g;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gates_sent++;
    endtask

    // sender holds off until every noise beat is back and the queue is empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rows_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_noise_budget(bpep_pkg::noise_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        bpep_pkg::in_beat_t           plan [$];
        int                           n_gates;
        int                           n_depol;
        int                           pick;
        int                           span;
        bit                           wide;
        logic [bpep_pkg::QUBIT_W-1:0] base;
        logic [bpep_pkg::QUBIT_W-1:0] qa;
        logic [bpep_pkg::QUBIT_W-1:0] qb;
        bpep_pkg::row_max_t           mask;
        bpep_pkg::kind_e              k;
        bpep_pkg::noise_t             total;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---------------- directed part ----------------
        write_noise_budget(20'd3);
        // noise gate before any start: counter is still zero, so overrun
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd5, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_START, 6'd0, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_MEAS, 6'd0, 6'd0, '1));
        // observable bit plus the lowest detector
        send_gate(gate(bpep_pkg::KIND_MEAS, 6'd1, 6'd0, 64'h8000_0000_0000_0001));
        send_gate(gate(bpep_pkg::KIND_MEAS, 6'd63, 6'd63, 64'hA5A5_5A5A_F00F_0FF0));
        send_gate(gate(bpep_pkg::KIND_CNOT, 6'd0, 6'd1, '0));
        send_gate(gate(bpep_pkg::KIND_CNOT, 6'd63, 6'd0, '1));
        // control equal to target is dropped
        send_gate(gate(bpep_pkg::KIND_CNOT, 6'd1, 6'd1, '0));
        send_gate(gate(bpep_pkg::KIND_HAD, 6'd1, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_PHASE, 6'd0, 6'd63, '0));
        send_gate(gate(bpep_pkg::KIND_PAULI, 6'd0, 6'd63, '1));
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd0, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_RESET, 6'd63, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd63, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd1, 6'd0, '0));
        // counter used up: overrun with index zero, sticky from here
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd1, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd0, 6'd0, '0));
        // a fresh start clears the flag and reloads the counter
        send_gate(gate(bpep_pkg::KIND_START, 6'd0, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_MEAS, 6'd2, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd2, 6'd0, '0));
        wait_drained();

        // counter extremes
        write_noise_budget(20'hFFFFF);
        send_gate(gate(bpep_pkg::KIND_START, 6'd0, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd3, 6'd0, '0));
        wait_drained();
        write_noise_budget(20'h00000);
        send_gate(gate(bpep_pkg::KIND_START, 6'd0, 6'd0, '0));
        send_gate(gate(bpep_pkg::KIND_DEPOL, 6'd3, 6'd0, '0));
        wait_drained();

        // ---------------- random circuits ----------------
        while (gates_sent < GATE_TARGET) begin
            plan.delete();
            n_depol = 0;
            n_gates = $urandom_range(0, 5) == 0 ? $urandom_range(5, 20)
                                                : $urandom_range(30, 110);
            // most circuits live on a few qubits so that rows interact
            wide = ($urandom_range(0, 4) == 0);
            span = $urandom_range(2, 10);
            base = 6'($urandom_range(0, 63));
            for (int i = 0; i < n_gates; i++) begin
                pick = $urandom_range(0, 99);
                if      (pick < 18) k = bpep_pkg::KIND_DEPOL;
                else if (pick < 33) k = bpep_pkg::KIND_MEAS;
                else if (pick < 38) k = bpep_pkg::KIND_RESET;
                else if (pick < 63) k = bpep_pkg::KIND_CNOT;
                else if (pick < 75) k = bpep_pkg::KIND_HAD;
                else if (pick < 87) k = bpep_pkg::KIND_PHASE;
                else if (pick < 92) k = bpep_pkg::KIND_PAULI;
                else if (pick < 94) k = bpep_pkg::KIND_START;
                else                k = bpep_pkg::kind_e'($urandom_range(0, 7));
                qa = wide ? 6'($urandom_range(0, 63)) : base + 6'($urandom_range(0, span - 1));
                qb = 6'($urandom_range(0, 63));
                if (k == bpep_pkg::KIND_CNOT) begin
                    if ($urandom_range(0, 19) == 0)
                        qb = qa;
                    else if (!wide)
                        qb = base + 6'($urandom_range(0, span - 1));
                end
                case ($urandom_range(0, 5))
                    0:       mask = {$urandom, $urandom};
                    1:       mask = bpep_pkg::row_max_t'(1)
                                    << $urandom_range(0, bpep_pkg::ROW_MAX - 1);
                    2:       mask = {1'b1, 63'($urandom)};
                    3:       mask = '0;
                    4:       mask = '1;
                    default: mask = {$urandom, $urandom} & {$urandom, $urandom};
                endcase
                if (k == bpep_pkg::KIND_DEPOL)
                    n_depol++;
                plan.push_back(gate(k, qa, qb, mask));
            end

            // noise budget: mostly enough, sometimes short to force overrun
            case ($urandom_range(0, 9))
                0:       total = 20'h00000;
                1:       total = 20'hFFFFF;
                2:       total = bpep_pkg::noise_t'($urandom);
                3, 4:    total = bpep_pkg::noise_t'(n_depol > 3 ?
                                                    n_depol - $urandom_range(1, 3) : 0);
                default: total = bpep_pkg::noise_t'(n_depol + $urandom_range(0, 5));
            endcase

            // a register write needs an idle core; some circuits run back to back
            if ($urandom_range(0, 3) != 0) begin
                wait_drained();
                write_noise_budget(total);
            end
            // without a start the new budget waits for the next one
            if ($urandom_range(0, 4) != 0)
                send_gate(gate(bpep_pkg::KIND_START, 6'($urandom), 6'($urandom),
                               {$urandom, $urandom}));
            quiet = (gates_sent >= QUIET_FROM);
            foreach (plan[i]) begin
                send_gate(plan[i]);
                quiet = (gates_sent >= QUIET_FROM);
            end
            circuits_run++;
        end

        // ---------------- drain and verdict ----------------
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("ran %0d gates over %0d random circuits plus directed cases", gates_sent,
                 circuits_run);
        $display("compared %0d noise row beats under idle and stall bursts", rows_checked);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("** backward_pauli_error_propagation_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d noise beats never arrived", fail_count, rows_pending);
            $display("** backward_pauli_error_propagation_core: FAILED **");
        end
        $finish;
    end

endmodule
